// ----- rtl/assoc_cache_fifo_range_invalidate_macros.svh -----
// Assertion macros used by the checker file.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSOC_CACHE_FIFO_RANGE_INVALIDATE_MACROS_SVH
`define ASSOC_CACHE_FIFO_RANGE_INVALIDATE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ACFRI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("acfri assertion failed");

// Next-cycle implication, disabled during reset.
`define ACFRI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("acfri assertion failed");

`endif

// ----- rtl/acfri_pkg.sv -----
// Package for the associative cache: action codes, control struct, defaults.
// No dependencies.
package acfri_pkg;

  localparam int unsigned ENTRIES_DEF    = 128;
  localparam int unsigned KEY_BITS_DEF   = 16;
  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned ACTION_BITS    = 2;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_STORE  = 2'd1,
    ACT_INVAL  = 2'd2,
    ACT_CLEAR  = 2'd3
  } acfri_action_e;

  // Control that travels with a command beat from cell to cell.
  typedef struct packed {
    logic          vld;
    acfri_action_e action;
    logic          hit;
  } acfri_ctl_t;

endpackage

// ----- rtl/acfri_if.sv -----
// Request and response channel interfaces of the associative cache.
// Uses acfri_pkg for the action field width.
interface acfri_req_if #(
  parameter int unsigned KEY_BITS   = acfri_pkg::KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = acfri_pkg::VALUE_BITS_DEF
) ();
  logic                               valid;
  logic                               ready;
  logic [acfri_pkg::ACTION_BITS-1:0]  action;
  logic [KEY_BITS-1:0]                key;
  logic [VALUE_BITS-1:0]              payload;
  logic [KEY_BITS-1:0]                range_top;

  modport source (output valid, action, key, payload, range_top, input ready);
  modport sink   (input valid, action, key, payload, range_top, output ready);
endinterface

interface acfri_rsp_if #(
  parameter int unsigned VALUE_BITS = acfri_pkg::VALUE_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [VALUE_BITS-1:0] found_value;

  modport source (output valid, hit, found_value, input ready);
  modport sink   (input valid, hit, found_value, output ready);
endinterface

// ----- rtl/assoc_cache_fifo_range_invalidate.sv -----
// Top level of the fully associative key/value cache with FIFO replacement.
// Depends on acfri_pkg, acfri_if (acfri_req_if, acfri_rsp_if) and acfri_cell.
//
//  channel | dir | handshake      | fields
//  --------+-----+----------------+-------------------------------------
//  req_i   | in  | valid / ready  | action, key, payload, range_top
//  rsp_o   | out | valid / ready  | hit, found_value
//
// Flow: a request beat walks the row of ENTRIES cells, one cell per
//   clock while the row is not stalled; each cell registers the beat, and
//   the last cell's register drives rsp_o. The row is a pipeline, so one
//   beat per cycle is taken in steady state while rsp_o is not stalled.
// Reset: all slot valid bits, the pipeline valids and the replacement
//   pointer clear at once; no clearing pass is needed.
// Stalls: the whole row holds while a response waits on rsp_o.ready; the
//   last cell's register is the output register.
module assoc_cache_fifo_range_invalidate #(
  parameter int unsigned ENTRIES    = acfri_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_BITS   = acfri_pkg::KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = acfri_pkg::VALUE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  acfri_req_if.sink   req_i,
  acfri_rsp_if.source rsp_o
);
  import acfri_pkg::*;

  // Slot index width; one bit minimum so a single-entry cache still builds.
  localparam int unsigned PTR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(ENTRIES - 1);

  // Stage s feeds cell s; stage ENTRIES is the last cell's output register.
  acfri_ctl_t            ctl_s     [ENTRIES+1];
  logic [KEY_BITS-1:0]   key_s     [ENTRIES+1];
  logic [VALUE_BITS-1:0] payload_s [ENTRIES+1];
  logic [KEY_BITS-1:0]   top_s     [ENTRIES+1];
  logic [PTR_W-1:0]      idx_s     [ENTRIES+1];
  logic [VALUE_BITS-1:0] value_s   [ENTRIES+1];

  logic             adv;
  logic [PTR_W-1:0] ptr_q, ptr_d;

  // Row moves whenever the output register is empty or being drained.
  assign adv         = !ctl_s[ENTRIES].vld || rsp_o.ready;
  assign req_i.ready = adv;

  // Replacement pointer: each accepted store claims the slot under it.
  always_comb begin
    ptr_d = ptr_q;
    if (req_i.valid && adv && (acfri_action_e'(req_i.action) == ACT_STORE)) begin
      ptr_d = (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else begin
      ptr_q <= ptr_d;
    end
  end

  // Head of the row: a fresh beat starts with no hit and a zero value.
  assign ctl_s[0].vld    = req_i.valid;
  assign ctl_s[0].action = acfri_action_e'(req_i.action);
  assign ctl_s[0].hit    = 1'b0;
  assign key_s[0]        = req_i.key;
  assign payload_s[0]    = req_i.payload;
  assign top_s[0]        = req_i.range_top;
  assign idx_s[0]        = ptr_q;
  assign value_s[0]      = '0;

  for (genvar c = 0; c < ENTRIES; c++) begin : g_cell
    acfri_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS),
      .PTR_W      (PTR_W),
      .CELL_ID    (c)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .adv_i     (adv),
      .ctl_i     (ctl_s[c]),
      .key_i     (key_s[c]),
      .payload_i (payload_s[c]),
      .top_i     (top_s[c]),
      .idx_i     (idx_s[c]),
      .value_i   (value_s[c]),
      .ctl_o     (ctl_s[c+1]),
      .key_o     (key_s[c+1]),
      .payload_o (payload_s[c+1]),
      .top_o     (top_s[c+1]),
      .idx_o     (idx_s[c+1]),
      .value_o   (value_s[c+1])
    );
  end

  assign rsp_o.valid       = ctl_s[ENTRIES].vld;
  assign rsp_o.hit         = ctl_s[ENTRIES].hit;
  assign rsp_o.found_value = value_s[ENTRIES];

endmodule

// ----- rtl/acfri_cell.sv -----
// One cache slot plus the command register that hands a beat to the next cell.
// Depends on acfri_pkg.
module acfri_cell #(
  parameter int unsigned KEY_BITS   = acfri_pkg::KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = acfri_pkg::VALUE_BITS_DEF,
  parameter int unsigned PTR_W      = 7,
  parameter int unsigned CELL_ID    = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  acfri_pkg::acfri_ctl_t ctl_i,
  input  logic [KEY_BITS-1:0]   key_i,
  input  logic [VALUE_BITS-1:0] payload_i,
  input  logic [KEY_BITS-1:0]   top_i,
  input  logic [PTR_W-1:0]      idx_i,
  input  logic [VALUE_BITS-1:0] value_i,
  output acfri_pkg::acfri_ctl_t ctl_o,
  output logic [KEY_BITS-1:0]   key_o,
  output logic [VALUE_BITS-1:0] payload_o,
  output logic [KEY_BITS-1:0]   top_o,
  output logic [PTR_W-1:0]      idx_o,
  output logic [VALUE_BITS-1:0] value_o
);
  import acfri_pkg::*;

  localparam logic [PTR_W-1:0] MY_ID = PTR_W'(CELL_ID);

  logic                  ent_vld_q, ent_vld_d;
  logic [KEY_BITS-1:0]   ent_key_q;
  logic [VALUE_BITS-1:0] ent_val_q;
  logic                  ent_wr;

  acfri_ctl_t            ctl_q, ctl_d;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] payload_q;
  logic [KEY_BITS-1:0]   top_q;
  logic [PTR_W-1:0]      idx_q;
  logic [VALUE_BITS-1:0] value_q, value_d;

  logic key_eq, in_range;

  assign key_eq   = ent_vld_q && (ent_key_q == key_i);
  assign in_range = ent_vld_q && (ent_key_q >= key_i) && (ent_key_q <= top_i);

  always_comb begin
    ctl_d     = ctl_i;
    value_d   = value_i;
    ent_vld_d = ent_vld_q;
    ent_wr    = 1'b0;
    if (ctl_i.vld) begin
      unique case (ctl_i.action)
        ACT_LOOKUP: begin
          // first (lowest) matching cell wins
          if (!ctl_i.hit && key_eq) begin
            ctl_d.hit = 1'b1;
            value_d   = ent_val_q;
          end
        end
        ACT_STORE: begin
          if (idx_i == MY_ID) begin
            ent_wr    = 1'b1;
            ent_vld_d = 1'b1;
          end
        end
        ACT_INVAL: begin
          if (in_range) ent_vld_d = 1'b0;
        end
        ACT_CLEAR: begin
          ent_vld_d = 1'b0;
        end
        default: begin
          ent_vld_d = ent_vld_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= 1'b0;
      ctl_q     <= '0;
    end else if (adv_i) begin
      ent_vld_q <= ent_vld_d;
      ctl_q     <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (ent_wr) begin
        ent_key_q <= key_i;
        ent_val_q <= payload_i;
      end
      key_q     <= key_i;
      payload_q <= payload_i;
      top_q     <= top_i;
      idx_q     <= idx_i;
      value_q   <= value_d;
    end
  end

  assign ctl_o     = ctl_q;
  assign key_o     = key_q;
  assign payload_o = payload_q;
  assign top_o     = top_q;
  assign idx_o     = idx_q;
  assign value_o   = value_q;

endmodule

// ----- rtl/acfri_checker.sv -----
// Port-level checker for the associative cache, bound to the top level.
// Depends on assoc_cache_fifo_range_invalidate_macros.svh.
`include "assoc_cache_fifo_range_invalidate_macros.svh"

module acfri_checker #(
  parameter int unsigned VALUE_BITS = acfri_pkg::VALUE_BITS_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  req_valid_i,
  input logic                  req_ready_i,
  input logic                  rsp_valid_i,
  input logic                  rsp_ready_i,
  input logic                  rsp_hit_i,
  input logic [VALUE_BITS-1:0] rsp_found_value_i
);

  // A response beat that is not taken stays up.
  `ACFRI_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i)

  // A miss or a non-lookup never carries a value.
  `ACFRI_ASSERT_NOW(a_miss_zero, rsp_valid_i && !rsp_hit_i, rsp_found_value_i == '0)

  // Backpressure on requests only comes from a stalled response.
  `ACFRI_ASSERT_NOW(a_ready_src, !req_ready_i, rsp_valid_i && !rsp_ready_i)

  // Nothing comes out right after reset.
  `ACFRI_ASSERT_NOW(a_rst_empty, $rose(rst_ni), !rsp_valid_i && req_ready_i)

endmodule

bind assoc_cache_fifo_range_invalidate acfri_checker #(
  .VALUE_BITS (VALUE_BITS)
) u_acfri_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_hit_i         (rsp_o.hit),
  .rsp_found_value_i (rsp_o.found_value)
);
